FILE: rtl/core/d2q_pkg.sv
// ----------------------------------------------------------------------------
// d2q_pkg
// shared constants for the d2q9 bgk collision pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package d2q_pkg;

    // number of lattice directions carried per node
    localparam int NUM_DIR = 9;

    // relaxation register: unsigned q1.24, resets to 1.0
    localparam int CFG_W = 25;
    localparam logic [CFG_W-1:0] CFG_RESET = 25'd16777216;

endpackage

`default_nettype wire

FILE: rtl/core/d2q9_bgk_collision.sv
// throughput: one lattice node per cycle, set by the fully pipelined divider and multipliers
// the long-division pipeline (one quotient bit per stage) dominates the latency
// a stall on the output freezes the whole pipeline; nothing is dropped or repeated
// reset (rst_n low, asynchronous) clears all valid bits and sets 1/tau to 1.0
// ----------------------------------------------------------------------------
// d2q9_bgk_collision
// d2q9 lattice boltzmann bgk collision of one node per cycle, signed fixed point
// ----------------------------------------------------------------------------
`default_nettype none

module d2q9_bgk_collision #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // relaxation register write
    input  wire logic                             cfg_wr_en,
    input  wire logic [d2q_pkg::CFG_W-1:0]        cfg_wr_data,
    // node input
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // dist_rest, dist_east, dist_north, dist_west, dist_south,
    // dist_northeast, dist_northwest, dist_southwest, dist_southeast, zero pad
    input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                             s_axis_tlast,   // last_node
    // relaxed node output
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // post_rest, post_east, post_north, post_west, post_south,
    // post_northeast, post_northwest, post_southwest, post_southeast, zero pad
    output logic [((9*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    output logic                                  m_axis_tlast,   // last_node_out
    output logic                                  m_axis_tuser    // density_fault
);

    localparam int W       = DATA_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int ND      = d2q_pkg::NUM_DIR;
    localparam int TDATA_W = ((ND*W+7)/8)*8;
    localparam int XW      = W + 28;        // headroom for sums before saturation
    localparam int LD      = W + 2;         // divider latency
    localparam int TD      = 1 + LD;        // stage holding the quotients
    localparam int TE      = TD + 1;        // stage holding the velocities
    localparam int T_END   = TE + 9;        // last stage before the output register

    // elaboration-time constants
    localparam longint ONE_L  = longint'(1) <<< F;
    localparam longint MAXP_L = (longint'(1) <<< (W - 1)) - 1;
    localparam longint C3_L   = 3 * ONE_L;
    localparam longint C45_L  = (9 * ONE_L) / 2;
    localparam longint C15_L  = (3 * ONE_L) / 2;

    localparam logic signed [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(ONE_L);
    localparam logic signed [W-1:0] C3   = W'((C3_L > MAXP_L) ? MAXP_L : C3_L);
    localparam logic signed [W-1:0] C45  = W'((C45_L > MAXP_L) ? MAXP_L : C45_L);
    localparam logic signed [W-1:0] C15  = W'((C15_L > MAXP_L) ? MAXP_L : C15_L);
    localparam logic signed [W-1:0] WT2  = W'((ONE_L + 18) / 36);       // 1/36
    localparam logic signed [W-1:0] WT1  = W'((ONE_L + 4) / 9);         // 1/9
    localparam logic signed [W-1:0] WT0  = W'((4 * ONE_L + 4) / 9);     // 4/9

    // payload that rides alongside the arithmetic
    typedef struct packed {
        logic [8:0][W-1:0] s;
        logic              last;
        logic              fault;
        logic [W-1:0]      rho;
    } side_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        if (v > XW'(MAXP))
            return MAXP;
        else if (v < XW'(MINN))
            return MINN;
        else
            return v[W-1:0];
    endfunction

    logic                           pipe_en;
    logic [d2q_pkg::CFG_W-1:0]      inv_tau_reg;
    logic signed [W-1:0]            t11_reg;
    side_t                          side_reg [0:T_END];
    logic                           vld_reg  [0:T_END];

    // stall: everything advances together whenever the output can move
    assign pipe_en       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    // relaxation register and the derived 1 - 1/tau
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_tau_reg <= d2q_pkg::CFG_RESET;
        else if (cfg_wr_en)
            inv_tau_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        t11_reg <= sat_w(XW'(ONE) - XW'($signed({1'b0, inv_tau_reg})));
    end

    // valid bits follow the data down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= T_END; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k <= T_END; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // moments: density and the two momentum differences
    logic signed [XW-1:0] rho_x;
    logic signed [XW-1:0] mx_x;
    logic signed [XW-1:0] my_x;
    logic                 fault_c;
    logic signed [W+2:0]  mx_reg;
    logic signed [W+2:0]  my_reg;
    logic        [W+2:0]  den_reg;

    always_comb
    begin
        rho_x = '0;
        for (int j = 0; j < ND; j++)
            rho_x = rho_x + XW'($signed(side_reg[0].s[j]));
        mx_x = XW'($signed(side_reg[0].s[1])) + XW'($signed(side_reg[0].s[5]))
             + XW'($signed(side_reg[0].s[8])) - XW'($signed(side_reg[0].s[3]))
             - XW'($signed(side_reg[0].s[6])) - XW'($signed(side_reg[0].s[7]));
        my_x = XW'($signed(side_reg[0].s[2])) + XW'($signed(side_reg[0].s[5]))
             + XW'($signed(side_reg[0].s[6])) - XW'($signed(side_reg[0].s[4]))
             - XW'($signed(side_reg[0].s[7])) - XW'($signed(side_reg[0].s[8]));
        fault_c = rho_x <= XW'(0);
    end

    // side payload shift line; stage 1 adds density and the fault flag
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int j = 0; j < ND; j++)
                side_reg[0].s[j] <= s_axis_tdata[j*W +: W];
            side_reg[0].last  <= s_axis_tlast;
            side_reg[0].fault <= 1'b0;
            side_reg[0].rho   <= '0;

            side_reg[1].s     <= side_reg[0].s;
            side_reg[1].last  <= side_reg[0].last;
            side_reg[1].fault <= fault_c;
            side_reg[1].rho   <= sat_w(rho_x);
            for (int k = 2; k <= T_END; k++)
                side_reg[k] <= side_reg[k-1];

            mx_reg  <= (W+3)'(mx_x);
            my_reg  <= (W+3)'(my_x);
            // a non-positive density divides by one; the result is dropped later
            den_reg <= fault_c ? (W+3)'(1) : (W+3)'(rho_x);
        end
    end

    // velocities
    logic signed [W-1:0] qx;
    logic signed [W-1:0] qy;

    d2q_div #(.W(W), .F(F)) u_div_x (
        .clk (clk),
        .en  (pipe_en),
        .num (mx_reg),
        .den (den_reg),
        .quo (qx)
    );

    d2q_div #(.W(W), .F(F)) u_div_y (
        .clk (clk),
        .en  (pipe_en),
        .num (my_reg),
        .den (den_reg),
        .quo (qy)
    );

    // velocities forced to zero on a density fault, then the eight e.u terms
    logic signed [W-1:0] ux_reg;
    logic signed [W-1:0] uy_reg;
    logic [7:0][W:0]     eu_reg;
    logic [7:0][W:0]     eu_d1;
    logic [7:0][W:0]     eu_d2;
    logic [7:0][W:0]     eu_d3;
    logic signed [W-1:0] ux_c;
    logic signed [W-1:0] uy_c;

    assign ux_c = side_reg[TD].fault ? '0 : qx;
    assign uy_c = side_reg[TD].fault ? '0 : qy;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ux_reg    <= ux_c;
            uy_reg    <= uy_c;
            // negated velocity is not clipped, so it keeps one extra bit
            eu_reg[0] <= (W+1)'(ux_c);
            eu_reg[1] <= (W+1)'(uy_c);
            eu_reg[2] <= (W+1)'(-XW'(ux_c));
            eu_reg[3] <= (W+1)'(-XW'(uy_c));
            eu_reg[4] <= (W+1)'(sat_w(XW'(ux_c) + XW'(uy_c)));
            eu_reg[5] <= (W+1)'(sat_w(XW'(uy_c) - XW'(ux_c)));
            eu_reg[6] <= (W+1)'(sat_w(-XW'(ux_c) - XW'(uy_c)));
            eu_reg[7] <= (W+1)'(sat_w(XW'(ux_c) - XW'(uy_c)));
            eu_d1     <= eu_reg;
            eu_d2     <= eu_d1;
            eu_d3     <= eu_d2;
        end
    end

    // first multiply rank: |u|^2 parts, rho/tau, 4.5 * e.u
    logic signed [W-1:0] uxx;
    logic signed [W-1:0] uyy;
    logic signed [W-1:0] rt;
    logic signed [W-1:0] ci [0:7];

    d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_uxx (
        .clk (clk), .en (pipe_en), .a (ux_reg), .b (ux_reg), .y (uxx)
    );

    d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_uyy (
        .clk (clk), .en (pipe_en), .a (uy_reg), .b (uy_reg), .y (uyy)
    );

    d2q_mulq #(.AW(W), .BW(d2q_pkg::CFG_W+1), .W(W), .F(F)) u_mul_rt (
        .clk (clk),
        .en  (pipe_en),
        .a   ($signed(side_reg[TE].rho)),
        .b   ($signed({1'b0, inv_tau_reg})),
        .y   (rt)
    );

    for (genvar i = 0; i < 8; i++)
    begin : g_ci
        d2q_mulq #(.AW(W), .BW(W+1), .W(W), .F(F)) u_mul_ci (
            .clk (clk), .en (pipe_en), .a (C45), .b ($signed(eu_reg[i])), .y (ci[i])
        );
    end

    // first add rank
    logic signed [W-1:0] usq_reg;
    logic signed [W-1:0] rt_a1;
    logic signed [W-1:0] inner_reg [0:7];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            usq_reg <= sat_w(XW'(uxx) + XW'(uyy));
            rt_a1   <= rt;
            for (int i = 0; i < 8; i++)
                inner_reg[i] <= sat_w(XW'(C3) + XW'(ci[i]));
        end
    end

    // second multiply rank: 1.5 |u|^2, weighted rho/tau, e.u * inner
    logic signed [W-1:0] kq;
    logic signed [W-1:0] w0;
    logic signed [W-1:0] w1;
    logic signed [W-1:0] w2;
    logic signed [W-1:0] pe [0:7];

    d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_k (
        .clk (clk), .en (pipe_en), .a (C15), .b (usq_reg), .y (kq)
    );

    d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_w0 (
        .clk (clk), .en (pipe_en), .a (rt_a1), .b (WT0), .y (w0)
    );

    d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_w1 (
        .clk (clk), .en (pipe_en), .a (rt_a1), .b (WT1), .y (w1)
    );

    d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_w2 (
        .clk (clk), .en (pipe_en), .a (rt_a1), .b (WT2), .y (w2)
    );

    for (genvar i = 0; i < 8; i++)
    begin : g_pe
        d2q_mulq #(.AW(W+1), .BW(W), .W(W), .F(F)) u_mul_pe (
            .clk (clk), .en (pipe_en), .a ($signed(eu_d3[i])), .b (inner_reg[i]), .y (pe[i])
        );
    end

    // common term 1 - 1.5|u|^2, then the per-direction polynomial
    logic signed [W-1:0] csq_reg;
    logic signed [W-1:0] pe_a2 [0:7];
    logic signed [W-1:0] w0_a2;
    logic signed [W-1:0] w1_a2;
    logic signed [W-1:0] w2_a2;
    logic signed [W-1:0] poly_reg [0:8];
    logic signed [W-1:0] w0_a3;
    logic signed [W-1:0] w1_a3;
    logic signed [W-1:0] w2_a3;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            csq_reg <= sat_w(XW'(ONE) - XW'(kq));
            for (int i = 0; i < 8; i++)
                pe_a2[i] <= pe[i];
            w0_a2 <= w0;
            w1_a2 <= w1;
            w2_a2 <= w2;

            poly_reg[0] <= csq_reg;
            for (int i = 0; i < 8; i++)
                poly_reg[i+1] <= sat_w(XW'(pe_a2[i]) + XW'(csq_reg));
            w0_a3 <= w0_a2;
            w1_a3 <= w1_a2;
            w2_a3 <= w2_a2;
        end
    end

    // third multiply rank: (1 - 1/tau) f and weight * poly
    logic signed [W-1:0] pa [0:8];
    logic signed [W-1:0] pb [0:8];

    for (genvar j = 0; j < 9; j++)
    begin : g_relax
        logic signed [W-1:0] wsel;

        if (j == 0)
        begin : g_w0
            assign wsel = w0_a3;
        end
        else if (j < 5)
        begin : g_w1
            assign wsel = w1_a3;
        end
        else
        begin : g_w2
            assign wsel = w2_a3;
        end

        d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_a (
            .clk (clk), .en (pipe_en), .a (t11_reg),
            .b ($signed(side_reg[TE+7].s[j])), .y (pa[j])
        );

        d2q_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mul_b (
            .clk (clk), .en (pipe_en), .a (wsel), .b (poly_reg[j]), .y (pb[j])
        );
    end

    // output register: holds a finished transaction while the sink stalls
    logic [8:0][W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_fault_reg;
    logic              out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_en)
            out_valid_reg <= vld_reg[T_END];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int j = 0; j < 9; j++)
                out_data_reg[j] <= sat_w(XW'(pa[j]) + XW'(pb[j]));
            out_last_reg  <= side_reg[T_END].last;
            out_fault_reg <= side_reg[T_END].fault;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_fault_reg;

endmodule

`default_nettype wire

FILE: rtl/core/d2q_div.sv
// ----------------------------------------------------------------------------
// d2q_div
// pipelined restoring divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
`default_nettype none

module d2q_div #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic signed [W+2:0] num,
    input  wire logic        [W+2:0] den,
    output logic signed      [W-1:0] quo
);

    localparam int SH = W - F;
    localparam int RW = W + 3;
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    logic [RW-1:0] r_reg   [0:W-1];
    logic [RW-1:0] den_reg [0:W-1];
    logic [W-1:0]  nb_reg  [0:W-1];
    logic [W-1:0]  q_reg   [0:W];
    logic          neg_reg [0:W];
    logic          ovf_reg [0:W];
    logic signed [W-1:0] quo_reg;

    logic [RW-1:0] mag;
    logic          num_neg;

    assign num_neg = num[W+2];
    assign mag     = num_neg ? RW'(-num) : RW'(num);

    // set-up: quotient of 2^W or more saturates straight away
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= mag >> SH;
            den_reg[0] <= den;
            nb_reg[0]  <= {mag[SH-1:0], {F{1'b0}}};
            q_reg[0]   <= '0;
            neg_reg[0] <= num_neg;
            ovf_reg[0] <= (mag >> SH) >= den;
        end
    end

    for (genvar k = 1; k <= W; k++)
    begin : g_stage
        logic [RW:0] trial;
        logic        ge;

        assign trial = {r_reg[k-1], nb_reg[k-1][W-1]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= {q_reg[k-1][W-2:0], ge};
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]   <= ge ? RW'(trial - {1'b0, den_reg[k-1]}) : trial[RW-1:0];
                    den_reg[k] <= den_reg[k-1];
                    nb_reg[k]  <= nb_reg[k-1] << 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[W])
                quo_reg <= (ovf_reg[W] || (q_reg[W] > MINN)) ? MINN : -q_reg[W];
            else
                quo_reg <= (ovf_reg[W] || q_reg[W][W-1]) ? MAXP : q_reg[W];
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/core/d2q_mulq.sv
// ----------------------------------------------------------------------------
// d2q_mulq
// two-stage fixed point multiply, round half away from zero, saturate
// ----------------------------------------------------------------------------
`default_nettype none

module d2q_mulq #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int W  = 32,
    parameter int F  = 24
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic signed      [W-1:0]  y
);

    localparam int PW = AW + BW;
    localparam logic [PW:0]  HALF  = (PW+1)'(1) << (F - 1);
    localparam logic [PW:0]  LIM_P = ((PW+1)'(1) << (W - 1)) - (PW+1)'(1);
    localparam logic [PW:0]  LIM_N = (PW+1)'(1) << (W - 1);
    localparam logic [W-1:0] MAXP  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN  = {1'b1, {(W-1){1'b0}}};

    logic signed [PW-1:0] prod_reg;
    logic signed [W-1:0]  y_reg;
    logic                 neg;
    logic [PW-1:0]        mag;
    logic [PW:0]          rnd;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= a * b;
    end

    assign neg = prod_reg[PW-1];
    assign mag = neg ? PW'(-prod_reg) : PW'(prod_reg);
    assign rnd = ({1'b0, mag} + HALF) >> F;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg)
                y_reg <= (rnd > LIM_N) ? MINN : -rnd[W-1:0];
            else
                y_reg <= (rnd > LIM_P) ? MAXP : rnd[W-1:0];
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

FILE: rtl/core/d2q_checker.sv
// ----------------------------------------------------------------------------
// d2q_checker
// port-level checks for the collision pipeline, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module d2q_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                                              clk,
    input wire logic                                              rst_n,
    input wire logic                                              s_axis_tready,
    input wire logic                                              m_axis_tvalid,
    input wire logic                                              m_axis_tready,
    input wire logic [((d2q_pkg::NUM_DIR*DATA_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    input wire logic                                              m_axis_tlast,
    input wire logic                                              m_axis_tuser
);

    // a stalled output transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output transaction changed while stalled");

    // back-pressure reaches the input in the same cycle
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input ready while output stalled");

    // with the output free the pipeline always takes input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with idle output");

    // nothing comes out in the first cycle after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind d2q9_bgk_collision d2q_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (.*);

`default_nettype wire

FILE: verif/d2q9_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2q9_checker
// watches both node channels and the relaxation register port, works out the
// relaxed node for every input transaction and compares it with the output
// ----------------------------------------------------------------------------

module d2q9_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [d2q_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [287:0]              s_tdata,
    input  wire logic                      s_tlast,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [287:0]              m_tdata,
    input  wire logic                      m_tlast,
    input  wire logic                      m_tuser,
    output int                             fail_count,
    output int                             pending
);

    localparam int     FRAC = 24;
    localparam longint ONE  = longint'(1) << FRAC;
    localparam longint MAXP = 64'sd2147483647;
    localparam longint MINN = -64'sd2147483648;

    typedef struct packed {
        logic [287:0] post;
        logic         last;
        logic         fault;
    } relaxed_node_t;

    relaxed_node_t             expected_nodes[$];
    logic [d2q_pkg::CFG_W-1:0] inv_tau;

    function automatic longint sat32(longint v);
        if (v > MAXP) return MAXP;
        if (v < MINN) return MINN;
        return v;
    endfunction

    function automatic longint clamp_mag(logic neg, logic [127:0] m);
        if (neg) return (m > 128'd2147483648) ? MINN : -longint'(m[63:0]);
        return (m > 128'd2147483647) ? MAXP : longint'(m[63:0]);
    endfunction

    // product rounded half away from zero at the fraction point
    function automatic longint qmul(longint a, longint b);
        logic         neg;
        logic [63:0]  ma, mb;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = {64'd0, ma} * {64'd0, mb};
        p   = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        return clamp_mag(neg, p);
    endfunction

    // quotient truncated toward zero, divisor positive
    function automatic longint qdiv(longint n, longint d);
        logic [63:0]  mn;
        logic [127:0] q;
        mn = (n < 0) ? -n : n;
        q  = ({64'd0, mn} << FRAC) / {64'd0, d};
        return clamp_mag(n < 0, q);
    endfunction

    function automatic longint relax_dir(longint keep, longint f, longint wt, longint eu,
                                         longint csq);
        longint inner, poly;
        inner = sat32(3 * ONE + qmul((9 * ONE) / 2, eu));
        poly  = sat32(qmul(eu, inner) + csq);
        return sat32(qmul(keep, f) + qmul(wt, poly));
    endfunction

    function automatic relaxed_node_t collide(logic [287:0] d, logic last);
        relaxed_node_t res;
        longint f[9];
        longint r[9];
        longint rho, mx, my, ux, uy, keep, usq, csq, rt, w0, w1, w2;
        rho = 0;
        for (int i = 0; i < 9; i++)
        begin
            f[i] = longint'($signed(d[i*32 +: 32]));
            rho += f[i];
        end
        mx = (f[1] + f[5] + f[8]) - (f[3] + f[6] + f[7]);
        my = (f[2] + f[5] + f[6]) - (f[4] + f[7] + f[8]);
        ux = 0;
        uy = 0;
        // non-positive density: velocities forced to zero, relaxation still runs
        if (rho > 0)
        begin
            ux = qdiv(mx, rho);
            uy = qdiv(my, rho);
        end
        keep = sat32(ONE - longint'(inv_tau));
        usq  = sat32(qmul(ux, ux) + qmul(uy, uy));
        csq  = sat32(ONE - qmul((3 * ONE) / 2, usq));
        rt   = qmul(sat32(rho), longint'(inv_tau));
        w2   = qmul(rt, (ONE + 18) / 36);
        w1   = qmul(rt, (ONE + 4) / 9);
        w0   = qmul(rt, (4 * ONE + 4) / 9);
        r[0] = sat32(qmul(keep, f[0]) + qmul(w0, csq));
        r[1] = relax_dir(keep, f[1], w1, ux, csq);
        r[2] = relax_dir(keep, f[2], w1, uy, csq);
        r[3] = relax_dir(keep, f[3], w1, -ux, csq);
        r[4] = relax_dir(keep, f[4], w1, -uy, csq);
        r[5] = relax_dir(keep, f[5], w2, sat32(ux + uy), csq);
        r[6] = relax_dir(keep, f[6], w2, sat32(uy - ux), csq);
        r[7] = relax_dir(keep, f[7], w2, sat32(-ux - uy), csq);
        r[8] = relax_dir(keep, f[8], w2, sat32(ux - uy), csq);
        for (int i = 0; i < 9; i++)
            res.post[i*32 +: 32] = r[i][31:0];
        res.last  = last;
        res.fault = (rho <= 0);
        return res;
    endfunction

    string dir_name[9] = '{"post_rest", "post_east", "post_north", "post_west", "post_south",
                           "post_northeast", "post_northwest", "post_southwest",
                           "post_southeast"};

    always @(posedge clk or negedge rst_n)
    begin
        relaxed_node_t exp_node;
        if (!rst_n)
        begin
            inv_tau    = d2q_pkg::CFG_RESET;
            fail_count = 0;
            expected_nodes.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                inv_tau = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_nodes.push_back(collide(s_tdata, s_tlast));
            if (m_tvalid && m_tready)
            begin
                if (expected_nodes.size() == 0)
                begin
                    $error("unexpected output transaction");
                    fail_count++;
                end
                else
                begin
                    exp_node = expected_nodes.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_tdata[i*32 +: 32] !== exp_node.post[i*32 +: 32])
                        begin
                            $error("%s expected %h actual %h", dir_name[i],
                                   exp_node.post[i*32 +: 32], m_tdata[i*32 +: 32]);
                            fail_count++;
                        end
                    if (m_tlast !== exp_node.last)
                    begin
                        $error("last_node_out expected %b actual %b", exp_node.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== exp_node.fault)
                    begin
                        $error("density_fault expected %b actual %b", exp_node.fault, m_tuser);
                        fail_count++;
                    end
                end
            end
            pending = expected_nodes.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the d2q9 bgk collision block: directed corner nodes,
// then random nodes under several relaxation settings with idling on both sides
// ----------------------------------------------------------------------------

module tb_top;

    localparam int     ONE_Q   = 1 << 24;
    localparam int     WD_LIMIT = 3000;   // idle cycles before the run is abandoned
    localparam int     DRAIN    = 60;     // extra wait once no expected node is pending

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [d2q_pkg::CFG_W-1:0] cfg_wr_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [287:0]              s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [287:0]              m_tdata;
    logic                      m_tlast;
    logic                      m_tuser;
    int                        fail_count;
    int                        pending;

    bit                        no_idle;       // stretch with both sides running flat out
    int                        hold_req;      // bumped to ask the receiver for a long stall
    int                        idle_cycles = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    d2q9_bgk_collision u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tlast (s_tlast),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tlast (m_tlast),
        .m_axis_tuser (m_tuser)
    );

    d2q9_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // watchdog: counts cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        int seen_req;
        int gap;
        seen_req = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != seen_req)
            begin
                // long stall so the pipeline fills and pushes back on the input
                seen_req = hold_req;
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    // offer one node and hold it until the transaction completes
    task automatic send_node(logic [287:0] node, logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= node;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sender pause: let every expected node come back, then the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_inv_tau(logic [d2q_pkg::CFG_W-1:0] val);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [287:0] splat(logic [31:0] v);
        logic [287:0] n;
        for (int i = 0; i < 9; i++)
            n[i*32 +: 32] = v;
        return n;
    endfunction

    // plausible node: non-negative populations near equilibrium, random content, now and then one negative
    function automatic logic [287:0] physical_node();
        logic [287:0] n;
        for (int i = 0; i < 9; i++)
            n[i*32 +: 32] = $urandom_range(0, ONE_Q / 2);
        if ($urandom_range(0, 9) == 0)
            n[$urandom_range(0, 8)*32 +: 32] = -$urandom_range(0, ONE_Q);
        return n;
    endfunction

    function automatic logic [287:0] random_node();
        logic [287:0] n;
        int           pick;
        n = physical_node();
        pick = $urandom_range(0, 9);
        if (pick < 3)
            for (int i = 0; i < 9; i++)
                n[i*32 +: 32] = $urandom();
        else if (pick < 5)
            for (int i = 0; i < 9; i++)
                case ($urandom_range(0, 3))
                    0: n[i*32 +: 32] = 32'h7fff_ffff;
                    1: n[i*32 +: 32] = 32'h8000_0000;
                    2: n[i*32 +: 32] = 32'd0;
                    default: n[i*32 +: 32] = $urandom_range(0, 3);
                endcase
        return n;
    endfunction

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_node(random_node(), 1'($urandom_range(0, 1)));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [287:0] n;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        no_idle     = 1'b0;
        hold_req    = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed nodes at the reset setting of 1/tau = 1.0
        send_node(splat(32'd0), 1'b0);                   // zero density fault
        send_node(splat(32'h7fff_ffff), 1'b1);
        send_node(splat(32'h8000_0000), 1'b0);           // negative density
        send_node(splat(32'hffff_ffff), 1'b1);
        send_node(splat(ONE_Q / 9), 1'b0);
        n = '0;
        n[1*32 +: 32] = 32'd1000;                        // tiny density, huge velocity
        n[3*32 +: 32] = -32'd999;
        send_node(n, 1'b1);
        n = '0;
        n[4*32 +: 32] = 32'd5;
        n[2*32 +: 32] = -32'd4;
        send_node(n, 1'b0);
        n = '0;
        n[0*32 +: 32] = 32'd1;                           // smallest positive density
        send_node(n, 1'b1);
        n = '0;
        n[5*32 +: 32] = ONE_Q;
        n[7*32 +: 32] = ONE_Q / 4;
        send_node(n, 1'b0);
        n = '0;
        n[6*32 +: 32] = 32'h7fff_ffff;
        n[8*32 +: 32] = 32'h8000_0001;
        n[0*32 +: 32] = 32'd2;
        send_node(n, 1'b1);
        for (int i = 0; i < 9; i++)
            n[i*32 +: 32] = (i == 0) ? 4 * ONE_Q / 9 : (i < 5 ? ONE_Q / 9 : ONE_Q / 36);
        send_node(n, 1'b0);

        // long receiver stall while the sender keeps offering
        hold_req = hold_req + 1;
        run_random(250);

        write_inv_tau('0);                              // no relaxation
        send_node(splat(ONE_Q / 9), 1'b1);
        run_random(150);
        write_inv_tau('1);                              // largest 1/tau, negative keep factor
        send_node(splat(32'h7fff_ffff), 1'b0);
        send_node(splat(32'h8000_0000), 1'b1);
        run_random(200);
        write_inv_tau(25'd8388608);                     // tau = 2
        run_random(250);
        write_inv_tau(25'($urandom_range(0, 33554431)));
        run_random(200);
        write_inv_tau(25'd1);
        hold_req = hold_req + 1;
        run_random(100);
        write_inv_tau(d2q_pkg::CFG_RESET);
        run_random(150);

        wait_idle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
